### rtl/otcts_pkg.sv
// Shared types, constants and a helper function of the offset-to-calendar converter.
`default_nettype none

package otcts_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 14;
    localparam int OFFSET_W   = 32;
    localparam int YEAR_W     = 14;
    localparam int SDAY_W     = 9;
    localparam int HOUR_W     = 5;
    localparam int MONTH_W    = 4;
    localparam int MDAY_W     = 5;
    localparam int MIN_W      = 6;
    localparam int SEC_W      = 6;
    localparam int U_W        = 33;
    localparam int DAYNUM_W   = 23;
    localparam int SOD_W      = 17;
    localparam int SHYEAR_W   = 15;
    localparam int MONTHS     = 12;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START_YEAR    = 2'd0,
        CFG_START_DAY     = 2'd1,
        CFG_START_HOUR    = 2'd2,
        CFG_KEEP_LEAP_DAY = 2'd3
    } cfg_index_t;

    localparam logic [YEAR_W-1:0] START_YEAR_RST = 14'd2010;
    localparam logic [SDAY_W-1:0] START_DAY_RST  = 9'd1;
    localparam logic [HOUR_W-1:0] START_HOUR_RST = 5'd0;
    localparam logic              KEEP_LEAP_RST  = 1'b0;

    localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
    localparam logic [33:0] OFFSET_BIAS    = 34'd2147558400;
    localparam logic [14:0] BIAS_DAYS      = 15'd24856;
    localparam logic [9:0]  YEAR_SHIFT_M1  = 10'd799;
    localparam logic [8:0]  DAYS_PER_YEAR  = 9'd365;
    localparam logic [8:0]  JAN1_FROM_MAR1 = 9'd306;
    localparam logic [9:0]  SECS_DIV128    = 10'd675;
    localparam logic [17:0] DAYS_PER_ERA   = 18'd146097;
    localparam logic [5:0]  SIXTY          = 6'd60;
    localparam logic [8:0]  YEARS_PER_ERA  = 9'd400;

    localparam logic [10:0] RECIP_25     = 11'd1311;
    localparam logic [26:0] RECIP_675    = 27'd101806633;
    localparam logic [23:0] RECIP_146097 = 24'd15051803;
    localparam logic [15:0] RECIP_15     = 16'd34953;
    localparam logic [18:0] RECIP_365    = 19'd367720;

    localparam logic [SHYEAR_W-1:0] YEAR_SHIFT = 15'd800;
    localparam logic [SHYEAR_W-1:0] YEAR_LO_SH = 15'd2200;
    localparam logic [SHYEAR_W-1:0] YEAR_HI_SH = 15'd10799;
    localparam logic [YEAR_W-1:0]   YEAR_LO    = 14'd1400;
    localparam logic [YEAR_W-1:0]   YEAR_HI    = 14'd9999;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [MDAY_W-1:0]  LEAP_DAY  = 5'd29;
    localparam logic [MDAY_W-1:0]  LAST_MDAY = 5'd31;
    localparam logic [HOUR_W-1:0]  LAST_HOUR = 5'd23;
    localparam logic [MIN_W-1:0]   LAST_MIN  = 6'd59;
    localparam logic [SEC_W-1:0]   LAST_SEC  = 6'd59;

    typedef struct packed {
        logic [YEAR_W-1:0] start_year;
        logic [SDAY_W-1:0] start_day;
        logic [HOUR_W-1:0] start_hour;
        logic              keep_leap_day;
    } cfg_t;

    typedef struct packed {
        logic [DAYNUM_W-1:0] daynum;
        logic [SOD_W-1:0]    sod;
    } day_t;

    typedef struct packed {
        logic [SHYEAR_W-1:0] year_sh;
        logic [MONTH_W-1:0]  month;
        logic [MDAY_W-1:0]   mday;
        logic [HOUR_W-1:0]   hour;
        logic [MIN_W-1:0]    minute;
        logic [SEC_W-1:0]    second;
    } date_t;

    // Day of a March-based year on which each month begins.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

### rtl/otcts_cfg_regs.sv
// Configuration register file of the offset-to-calendar converter.
`default_nettype none

module otcts_cfg_regs
    import otcts_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_we,
    input  wire [CFG_ADDR_W-1:0] cfg_addr,
    input  wire [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                 cfg
);

    logic [YEAR_W-1:0] start_year_reg, start_year_next;
    logic [SDAY_W-1:0] start_day_reg, start_day_next;
    logic [HOUR_W-1:0] start_hour_reg, start_hour_next;
    logic              keep_leap_reg, keep_leap_next;

    always_comb
    begin
        start_year_next = start_year_reg;
        start_day_next  = start_day_reg;
        start_hour_next = start_hour_reg;
        keep_leap_next  = keep_leap_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                CFG_START_YEAR:    start_year_next = cfg_wdata[YEAR_W-1:0];
                CFG_START_DAY:     start_day_next  = cfg_wdata[SDAY_W-1:0];
                CFG_START_HOUR:    start_hour_next = cfg_wdata[HOUR_W-1:0];
                CFG_KEEP_LEAP_DAY: keep_leap_next  = cfg_wdata[0];
                default:           keep_leap_next  = keep_leap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_year_reg <= START_YEAR_RST;
            start_day_reg  <= START_DAY_RST;
            start_hour_reg <= START_HOUR_RST;
            keep_leap_reg  <= KEEP_LEAP_RST;
        end
        else
        begin
            start_year_reg <= start_year_next;
            start_day_reg  <= start_day_next;
            start_hour_reg <= start_hour_next;
            keep_leap_reg  <= keep_leap_next;
        end
    end

    always_comb
    begin
        cfg.start_year    = start_year_reg;
        cfg.start_day     = start_day_reg;
        cfg.start_hour    = start_hour_reg;
        cfg.keep_leap_day = keep_leap_reg;
    end

endmodule

`default_nettype wire

### rtl/otcts_day_count.sv
// Pipeline that turns the offset and start point into a day number and second of day.
`default_nettype none

module otcts_day_count
    import otcts_pkg::*;
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    input  wire signed [OFFSET_W-1:0] offset,
    input  wire cfg_t                 cfg,
    output logic                      out_valid,
    output day_t                      out_day
);

    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [U_W-1:0]      u_reg, u_next;
    logic [22:0]         yy365_reg, yy365_next;
    logic [12:0]         q4_reg, q4_next;
    logic [7:0]          c100_reg, c100_next;
    logic [15:0]         q_reg, q_next;
    logic [9:0]          vlo_reg, vlo_next;
    logic [6:0]          ulo_reg, ulo_next;
    logic [DAYNUM_W-1:0] d0_reg, d0_next;
    logic [DAYNUM_W-1:0] z_reg, z_next;
    logic [SOD_W-1:0]    sod_reg, sod_next;

    logic [16:0] hour_secs;
    logic [U_W:0] u_sum;
    logic [14:0] yy;
    logic [23:0] c_prod;
    logic [23:0] jan1_sum;
    logic [52:0] q_prod;
    logic [25:0] rem_prod;
    logic [9:0]  rem;
    logic [23:0] z_sum;

    // The bias keeps the seconds sum non-negative; it is removed again as whole days.
    always_comb
    begin
        hour_secs  = 17'(cfg.start_hour) * 17'(SECS_PER_HOUR);
        u_sum      = {{(U_W + 1 - OFFSET_W){offset[OFFSET_W-1]}}, offset}
                   + (U_W + 1)'(hour_secs) + OFFSET_BIAS;
        u_next     = u_sum[U_W-1:0];
        yy         = 15'(cfg.start_year) + 15'(YEAR_SHIFT_M1);
        yy365_next = 23'(yy) * 23'(DAYS_PER_YEAR);
        q4_next    = yy[14:2];
        c_prod     = 24'(q4_next) * 24'(RECIP_25);
        c100_next  = c_prod[22:15];
    end

    always_comb
    begin
        jan1_sum = 24'(yy365_reg) + 24'(q4_reg) - 24'(c100_reg) + 24'(c100_reg[7:2])
                 + 24'(JAN1_FROM_MAR1) + 24'(cfg.start_day) - 24'd1;
        d0_next  = jan1_sum[DAYNUM_W-1:0];
        q_prod   = 53'(u_reg[U_W-1:7]) * 53'(RECIP_675);
        q_next   = q_prod[51:36];
        vlo_next = u_reg[16:7];
        ulo_next = u_reg[6:0];
    end

    always_comb
    begin
        rem_prod = 26'(q_reg) * 26'(SECS_DIV128);
        rem      = vlo_reg - rem_prod[9:0];
        sod_next = {rem, ulo_reg};
        z_sum    = 24'(d0_reg) + 24'(q_reg) - 24'(BIAS_DAYS);
        z_next   = z_sum[DAYNUM_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg     <= u_next;
        yy365_reg <= yy365_next;
        q4_reg    <= q4_next;
        c100_reg  <= c100_next;
        q_reg     <= q_next;
        vlo_reg   <= vlo_next;
        ulo_reg   <= ulo_next;
        d0_reg    <= d0_next;
        z_reg     <= z_next;
        sod_reg   <= sod_next;
    end

    always_comb
    begin
        out_valid      = s3_valid_reg;
        out_day.daynum = z_reg;
        out_day.sod    = sod_reg;
    end

endmodule

`default_nettype wire

### rtl/otcts_civil.sv
// Pipeline that splits a day number and second of day into a civil date and time.
`default_nettype none

module otcts_civil
    import otcts_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    input  wire day_t   in_day,
    output logic        out_valid,
    output date_t       out_date
);

    logic                s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic                s7_valid_reg, s8_valid_reg, s9_valid_reg;

    logic [DAYNUM_W-1:0] z4_reg;
    logic [5:0]          era4_reg, era4_next;
    logic [5:0]          era5_reg, era6_reg, era7_reg, era8_reg;
    logic [SOD_W-1:0]    sod4_reg;
    logic [10:0]         mt4_reg, mt4_next, mt5_reg;
    logic [17:0]         doe5_reg, doe5_next, doe6_reg, doe7_reg;
    logic [17:0]         w6_reg, w6_next;
    logic [8:0]          yoe7_reg, yoe7_next, yoe8_reg;
    logic [8:0]          doy8_reg, doy8_next;
    logic [SEC_W-1:0]    ss5_reg, ss5_next, ss6_reg, ss7_reg, ss8_reg;
    logic [HOUR_W-1:0]   hh5_reg, hh5_next, hh6_reg, hh7_reg, hh8_reg;
    logic [MIN_W-1:0]    mi6_reg, mi6_next, mi7_reg, mi8_reg;
    date_t               date_reg, date_next;

    logic [46:0] era_prod;
    logic [29:0] mt_prod;
    logic [22:0] era_days;
    logic [22:0] doe_diff;
    logic [16:0] sec_prod;
    logic [16:0] sec_diff;
    logic [23:0] hh_prod;
    logic [33:0] c1460_prod;
    logic [2:0]  c36524;
    logic [10:0] min_prod;
    logic [10:0] min_diff;
    logic [35:0] yoe_prod;
    logic [1:0]  cent;
    logic [17:0] year_days;
    logic [17:0] doy_diff;
    logic [3:0]  mp;
    logic [8:0]  mday_w;
    logic [3:0]  mon;

    always_comb
    begin
        era_prod  = 47'(in_day.daynum) * 47'(RECIP_146097);
        era4_next = era_prod[46:41];
        mt_prod   = 30'(in_day.sod[SOD_W-1:2]) * 30'(RECIP_15);
        mt4_next  = mt_prod[29:19];
    end

    always_comb
    begin
        era_days  = 23'(era4_reg) * 23'(DAYS_PER_ERA);
        doe_diff  = z4_reg - era_days;
        doe5_next = doe_diff[17:0];
        sec_prod  = 17'(mt4_reg) * 17'(SIXTY);
        sec_diff  = sod4_reg - sec_prod;
        ss5_next  = sec_diff[SEC_W-1:0];
        hh_prod   = 24'(mt4_reg[10:2]) * 24'(RECIP_15);
        hh5_next  = hh_prod[23:19];
    end

    // Years of the era follow from the day of era with the four-year, century and
    // four-century corrections taken out first.
    always_comb
    begin
        c1460_prod = 34'(doe5_reg[17:2]) * 34'(RECIP_365);
        c36524     = 3'(doe5_reg >= 18'd36524) + 3'(doe5_reg >= 18'd73048)
                   + 3'(doe5_reg >= 18'd109572) + 3'(doe5_reg >= 18'd146096);
        w6_next    = doe5_reg - 18'(c1460_prod[33:27]) + 18'(c36524)
                   - 18'(doe5_reg == 18'd146096);
        min_prod   = 11'(hh5_reg) * 11'(SIXTY);
        min_diff   = mt5_reg - min_prod;
        mi6_next   = min_diff[MIN_W-1:0];
    end

    always_comb
    begin
        yoe_prod  = 36'(w6_reg) * 36'(RECIP_365);
        yoe7_next = yoe_prod[35:27];
    end

    always_comb
    begin
        cent      = 2'(yoe7_reg >= 9'd100) + 2'(yoe7_reg >= 9'd200) + 2'(yoe7_reg >= 9'd300);
        year_days = 18'(yoe7_reg) * 18'(DAYS_PER_YEAR) + 18'(yoe7_reg[8:2]) - 18'(cent);
        doy_diff  = doe7_reg - year_days;
        doy8_next = doy_diff[8:0];
    end

    always_comb
    begin
        mp = 4'd0;
        for (int i = 1; i < MONTHS; i++)
        begin
            if (doy8_reg >= month_start(4'(i)))
            begin
                mp = mp + 4'd1;
            end
        end
        mday_w = doy8_reg - month_start(mp) + 9'd1;
        mon    = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
        date_next.year_sh = 15'(yoe8_reg) + 15'(era8_reg) * 15'(YEARS_PER_ERA)
                          + 15'(mon <= MONTH_FEB);
        date_next.month   = mon;
        date_next.mday    = mday_w[MDAY_W-1:0];
        date_next.hour    = hh8_reg;
        date_next.minute  = mi8_reg;
        date_next.second  = ss8_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else
        begin
            s4_valid_reg <= in_valid;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        z4_reg   <= in_day.daynum;
        sod4_reg <= in_day.sod;
        era4_reg <= era4_next;
        mt4_reg  <= mt4_next;

        era5_reg <= era4_reg;
        doe5_reg <= doe5_next;
        mt5_reg  <= mt4_reg;
        ss5_reg  <= ss5_next;
        hh5_reg  <= hh5_next;

        era6_reg <= era5_reg;
        doe6_reg <= doe5_reg;
        w6_reg   <= w6_next;
        ss6_reg  <= ss5_reg;
        hh6_reg  <= hh5_reg;
        mi6_reg  <= mi6_next;

        era7_reg <= era6_reg;
        doe7_reg <= doe6_reg;
        yoe7_reg <= yoe7_next;
        ss7_reg  <= ss6_reg;
        hh7_reg  <= hh6_reg;
        mi7_reg  <= mi6_reg;

        era8_reg <= era7_reg;
        yoe8_reg <= yoe7_reg;
        doy8_reg <= doy8_next;
        ss8_reg  <= ss7_reg;
        hh8_reg  <= hh7_reg;
        mi8_reg  <= mi7_reg;

        date_reg <= date_next;
    end

    always_comb
    begin
        out_valid = s9_valid_reg;
        out_date  = date_reg;
    end

endmodule

`default_nettype wire

### rtl/otcts_result.sv
// Result stage: leap-day handling, range clamp and the output register.
`default_nettype none

module otcts_result
    import otcts_pkg::*;
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire date_t          in_date,
    input  wire                 keep_leap_day,
    output logic                done,
    output logic [YEAR_W-1:0]   year,
    output logic [MONTH_W-1:0]  month,
    output logic [MDAY_W-1:0]   day,
    output logic [HOUR_W-1:0]   hour,
    output logic [MIN_W-1:0]    minute,
    output logic [SEC_W-1:0]    second,
    output logic                out_of_range
);

    logic                done_reg;
    logic [YEAR_W-1:0]   year_reg, year_next;
    logic [MONTH_W-1:0]  month_reg, month_next;
    logic [MDAY_W-1:0]   day_reg, day_next;
    logic [HOUR_W-1:0]   hour_reg, hour_next;
    logic [MIN_W-1:0]    minute_reg, minute_next;
    logic [SEC_W-1:0]    second_reg, second_next;
    logic                oor_reg, oor_next;

    logic [SHYEAR_W-1:0] year_diff;

    // A shifted year below the shift wraps around and counts as past the top end.
    always_comb
    begin
        year_diff   = in_date.year_sh - YEAR_SHIFT;
        year_next   = year_diff[YEAR_W-1:0];
        month_next  = in_date.month;
        day_next    = in_date.mday;
        hour_next   = in_date.hour;
        minute_next = in_date.minute;
        second_next = in_date.second;
        oor_next    = 1'b0;
        if (!keep_leap_day && in_date.month == MONTH_FEB && in_date.mday == LEAP_DAY)
        begin
            month_next = MONTH_MAR;
            day_next   = 5'd1;
        end
        if (in_date.year_sh < YEAR_SHIFT || in_date.year_sh > YEAR_HI_SH)
        begin
            year_next   = YEAR_HI;
            month_next  = MONTH_DEC;
            day_next    = LAST_MDAY;
            hour_next   = LAST_HOUR;
            minute_next = LAST_MIN;
            second_next = LAST_SEC;
            oor_next    = 1'b1;
        end
        else if (in_date.year_sh < YEAR_LO_SH)
        begin
            year_next   = YEAR_LO;
            month_next  = MONTH_JAN;
            day_next    = 5'd1;
            hour_next   = '0;
            minute_next = '0;
            second_next = '0;
            oor_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        second_reg <= second_next;
        oor_reg    <= oor_next;
    end

    always_comb
    begin
        done         = done_reg;
        year         = year_reg;
        month        = month_reg;
        day          = day_reg;
        hour         = hour_reg;
        minute       = minute_reg;
        second       = second_reg;
        out_of_range = oor_reg;
    end

endmodule

`default_nettype wire

### rtl/offset_to_calendar_timestamp_unit.sv
// Top level of the offset-to-calendar timestamp converter.
// An accepted word is registered, then passes the day-count, civil and result stages to done.
// Throughput: one word per cycle; busy stays low, the pipeline has one word in each stage.
// The receiver cannot stall: each result is shown for exactly one cycle under done.
// Reset clears the pipeline and sets the start point to 1 January 2010, hour 0, leap day off.
`default_nettype none

module offset_to_calendar_timestamp_unit
    import otcts_pkg::*;
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       start,
    output logic                      busy,
    input  wire signed [OFFSET_W-1:0] offset_seconds,
    input  wire                       cfg_we,
    input  wire [CFG_ADDR_W-1:0]      cfg_addr,
    input  wire [CFG_DATA_W-1:0]      cfg_wdata,
    output logic                      done,
    output logic [YEAR_W-1:0]         year,
    output logic [MONTH_W-1:0]        month,
    output logic [MDAY_W-1:0]         day,
    output logic [HOUR_W-1:0]         hour,
    output logic [MIN_W-1:0]          minute,
    output logic [SEC_W-1:0]          second,
    output logic                      out_of_range
);

    logic                       in_valid_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic                       accept;
    cfg_t                       cfg;
    logic                       day_valid;
    day_t                       day_word;
    logic                       date_valid;
    date_t                      date_word;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            offset_reg <= offset_seconds;
        end
    end

    otcts_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    otcts_day_count u_day_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .offset    (offset_reg),
        .cfg       (cfg),
        .out_valid (day_valid),
        .out_day   (day_word)
    );

    otcts_civil u_civil (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (day_valid),
        .in_day    (day_word),
        .out_valid (date_valid),
        .out_date  (date_word)
    );

    otcts_result u_result (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (date_valid),
        .in_date       (date_word),
        .keep_leap_day (cfg.keep_leap_day),
        .done          (done),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .out_of_range  (out_of_range)
    );

endmodule

`default_nettype wire

### rtl/otcts_checker.sv
// Port-level checks of the offset-to-calendar converter and their bind to the top level.
`default_nettype none

module otcts_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        start,
    input wire        busy,
    input wire        done,
    input wire [13:0] year,
    input wire [3:0]  month,
    input wire [4:0]  day,
    input wire [4:0]  hour,
    input wire [5:0]  minute,
    input wire [5:0]  second,
    input wire        out_of_range
);

    a_word_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##11 done
    ) else $error("An accepted word did not produce a result after 11 cycles.");

    a_result_has_word: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 11)
    ) else $error("A result appeared without an accepted word 11 cycles earlier.");

    a_clamp_values: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |->
            ((year == 14'd1400 && month == 4'd1 && day == 5'd1 &&
              hour == 5'd0 && minute == 6'd0 && second == 6'd0) ||
             (year == 14'd9999 && month == 4'd12 && day == 5'd31 &&
              hour == 5'd23 && minute == 6'd59 && second == 6'd59))
    ) else $error("A clamped result does not sit at an end of the year range.");

    a_fields_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && !out_of_range) |->
            (year >= 14'd1400 && year <= 14'd9999 && month >= 4'd1 && month <= 4'd12 &&
             day >= 5'd1 && day <= 5'd31 && hour <= 5'd23 && minute <= 6'd59 &&
             second <= 6'd59)
    ) else $error("A result field is outside its calendar range.");

endmodule

bind offset_to_calendar_timestamp_unit otcts_checker u_otcts_checker (.*);

`default_nettype wire
